// ===== src/rpcid_pkg.sv =====
// Package for the RPC header request-id extractor.
// Holds status codes, parse constants and the result record; no dependencies.
package rpcid_pkg;

  localparam int unsigned OFFSET_W = 11;
  localparam int unsigned HLEN_W   = 10;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_NOT_CALL = 3'd2;
  localparam logic [2:0] ST_HDR_LONG = 3'd3;
  localparam logic [2:0] ST_BAD_TYPE = 3'd4;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = 11'd2047;
  localparam logic [7:0]          CALL_BYTE  = 8'h01;
  localparam logic [7:0]          I64_TYPE   = 8'h0a;
  // distances from the end of the header to the type byte and the id bytes
  localparam logic [OFFSET_W:0]   TYPE_GAP   = 12'd12;
  localparam logic [OFFSET_W:0]   ID_GAP     = 12'd15;
  localparam logic [OFFSET_W:0]   ID_LAST    = 12'd22;
  localparam logic [HLEN_W-1:0]   MAX_HDR_RESET = 10'd256;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] message_id;
    logic [63:0] req_id;
  } result_t;

endpackage

// ===== src/rpcid_in_reg.sv =====
// Input register stage of the RPC header request-id extractor.
// Holds one byte transaction until the scan stage takes it; depends on nothing.
module rpcid_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_last
);

  logic accept;

  assign data_stall = held_valid && !take;
  assign accept     = data_valid && !data_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= data_byte;
      held_last <= end_of_message;
    end
  end

`ifndef ASSERT_OFF
  // a held byte that is not taken must stay in place
  a_hold: assert property (@(posedge clk) disable iff (rst)
    held_valid && !take |=> held_valid && $stable(held_byte) && $stable(held_last))
    else $error("input register lost a held byte");
  // a new byte is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    accept |-> !held_valid || take)
    else $error("input register overwritten");
  // the register empties or refills in the cycle after a take
  a_take_clear: assert property (@(posedge clk) disable iff (rst)
    take && !accept |=> !held_valid)
    else $error("input register did not drain");
`endif

endmodule

// ===== src/rpcid_scan.sv =====
// Per-byte header scanner of the RPC header request-id extractor.
// Keeps the per-message parse state and the message counter; uses rpcid_pkg.
module rpcid_scan (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [7:0]               data_byte,
  input  logic                     last,
  input  logic [rpcid_pkg::HLEN_W-1:0] max_header_len,
  output rpcid_pkg::result_t       result
);

  logic [rpcid_pkg::OFFSET_W-1:0] byte_offset, byte_offset_next;
  logic                           sign_bit, sign_bit_next;
  logic                           word_nonzero, word_nonzero_next;
  logic                           framed_flag, framed_flag_next;
  logic [rpcid_pkg::HLEN_W-1:0]   header_length, header_length_next;
  logic                           header_big, header_big_next;
  logic [63:0]                    id_shift, id_shift_next;
  logic [2:0]                     parse_status, parse_status_next;
  logic [31:0]                    message_counter;

  logic [rpcid_pkg::OFFSET_W-1:0] base;
  logic [rpcid_pkg::OFFSET_W-1:0] rel;
  logic [rpcid_pkg::OFFSET_W:0]   span;
  logic                           scan_en;
  logic                           is_ok;

  always_comb begin
    byte_offset_next   = byte_offset;
    sign_bit_next      = sign_bit;
    word_nonzero_next  = word_nonzero;
    framed_flag_next   = framed_flag;
    header_length_next = header_length;
    header_big_next    = header_big;
    id_shift_next      = id_shift;
    parse_status_next  = parse_status;
    base = '0;
    rel  = '0;
    span = '0;

    scan_en = (parse_status == rpcid_pkg::ST_SHORT) && (byte_offset != rpcid_pkg::OFFSET_MAX);

    if (scan_en) begin
      // leading word decides whether a 4-byte frame length precedes the message
      if (byte_offset == 11'd0) begin
        sign_bit_next     = data_byte[7];
        word_nonzero_next = |data_byte;
      end else if (byte_offset < 11'd4) begin
        word_nonzero_next = word_nonzero | (|data_byte);
      end
      if (byte_offset == 11'd3) begin
        framed_flag_next = word_nonzero_next && !sign_bit_next;
      end

      base = framed_flag_next ? 11'd4 : 11'd0;
      if (byte_offset >= 11'd3 && byte_offset >= base) begin
        rel = byte_offset - base;
        if (rel == 11'd3) begin
          if (data_byte != rpcid_pkg::CALL_BYTE) begin
            parse_status_next = rpcid_pkg::ST_NOT_CALL;
          end
        end else if (rel >= 11'd4 && rel <= 11'd7) begin
          // keep the low bits and a flag for anything above them
          header_big_next    = header_big | (|header_length[rpcid_pkg::HLEN_W-1:2]);
          header_length_next = {header_length[1:0], data_byte};
          if (rel == 11'd7 && (header_big_next || header_length_next > max_header_len)) begin
            parse_status_next = rpcid_pkg::ST_HDR_LONG;
          end
        end else if (rel >= 11'd8) begin
          span = {1'b0, rel} - {2'b00, header_length};
          if (!span[rpcid_pkg::OFFSET_W]) begin
            if (span == rpcid_pkg::TYPE_GAP) begin
              if (data_byte != rpcid_pkg::I64_TYPE) begin
                parse_status_next = rpcid_pkg::ST_BAD_TYPE;
              end
            end else if (span >= rpcid_pkg::ID_GAP && span <= rpcid_pkg::ID_LAST) begin
              id_shift_next = {id_shift[55:0], data_byte};
              if (span == rpcid_pkg::ID_LAST) begin
                parse_status_next = rpcid_pkg::ST_OK;
              end
            end
          end
        end
      end
    end

    if (byte_offset != rpcid_pkg::OFFSET_MAX) begin
      byte_offset_next = byte_offset + 11'd1;
    end
  end

  assign is_ok             = (parse_status_next == rpcid_pkg::ST_OK);
  assign result.status     = parse_status_next;
  assign result.message_id = is_ok ? message_counter : 32'd0;
  assign result.req_id     = is_ok ? id_shift_next : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset     <= '0;
      sign_bit        <= 1'b0;
      word_nonzero    <= 1'b0;
      framed_flag     <= 1'b0;
      header_length   <= '0;
      header_big      <= 1'b0;
      id_shift        <= '0;
      parse_status    <= rpcid_pkg::ST_SHORT;
      message_counter <= '0;
    end else if (step) begin
      if (last) begin
        byte_offset   <= '0;
        sign_bit      <= 1'b0;
        word_nonzero  <= 1'b0;
        framed_flag   <= 1'b0;
        header_length <= '0;
        header_big    <= 1'b0;
        id_shift      <= '0;
        parse_status  <= rpcid_pkg::ST_SHORT;
        if (is_ok) begin
          message_counter <= message_counter + 32'd1;
        end
      end else begin
        byte_offset   <= byte_offset_next;
        sign_bit      <= sign_bit_next;
        word_nonzero  <= word_nonzero_next;
        framed_flag   <= framed_flag_next;
        header_length <= header_length_next;
        header_big    <= header_big_next;
        id_shift      <= id_shift_next;
        parse_status  <= parse_status_next;
      end
    end
  end

`ifndef ASSERT_OFF
  // the counter moves only when a message closes with status ok
  a_count: assert property (@(posedge clk) disable iff (rst)
    !(step && last && is_ok) |=> $stable(message_counter))
    else $error("message counter moved without an ok message");
  // once a final status is reached it holds until the message ends
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    step && !last && parse_status != rpcid_pkg::ST_SHORT |=>
      parse_status == $past(parse_status))
    else $error("parse status changed after first error");
  // every message starts over at offset zero
  a_restart: assert property (@(posedge clk) disable iff (rst)
    step && last |=> byte_offset == '0 && parse_status == rpcid_pkg::ST_SHORT)
    else $error("per-message state not cleared");
`endif

endmodule

// ===== src/rpc_header_request_id_extractor.sv =====
// Top level of the RPC header request-id extractor.
// Instantiates rpcid_in_reg and rpcid_scan, holds the result register; uses rpcid_pkg.
//
// Takes one message byte per transaction on the data channel and returns one result
// transaction for each byte marked end_of_message. Throughput is one byte per clock while
// no last byte waits: every per-byte check is a compare against the running offset, done
// in one pass between the input register and the result register. Once the scanner takes
// a last byte from the input register, the result register loads and goes valid. The
// block keeps accepting bytes while a result waits to be taken; only a last byte that
// finds the result register full and stalled waits.
// The result carries the parse status; message_id and req_id are zero unless
// the status is ok, and the message id counter advances only on ok messages.
// max_header_len resets to 256; the user writes it through cfg_write/cfg_data while idle (not enforced).
module rpc_header_request_id_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [9:0]  cfg_data,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_message,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [31:0] message_id,
  output logic [63:0] req_id
);

  logic [rpcid_pkg::HLEN_W-1:0] max_header_len;
  logic                         held_valid;
  logic [7:0]                   held_byte;
  logic                         held_last;
  logic                         take;
  logic                         emit;
  rpcid_pkg::result_t           scan_result;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_header_len <= rpcid_pkg::MAX_HDR_RESET;
    end else if (cfg_write) begin
      max_header_len <= cfg_data;
    end
  end

  // advance a held byte unless it closes a message and the result slot stays full
  assign take = held_valid && (!held_last || !result_valid || !result_stall);
  assign emit = take && held_last;

  rpcid_in_reg u_in_reg (
    .clk            (clk),
    .rst            (rst),
    .data_valid     (data_valid),
    .data_stall     (data_stall),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .take           (take),
    .held_valid     (held_valid),
    .held_byte      (held_byte),
    .held_last      (held_last)
  );

  rpcid_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .step           (take),
    .data_byte      (held_byte),
    .last           (held_last),
    .max_header_len (max_header_len),
    .result         (scan_result)
  );

  // result register: load on a closing byte, drop once the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status     <= scan_result.status;
      message_id <= scan_result.message_id;
      req_id     <= scan_result.req_id;
    end
  end

`ifndef ASSERT_OFF
  // a new result only ever comes from a closing byte
  a_rise_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(emit))
    else $error("result appeared without a closing byte");
  // a failed message carries no ids
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != rpcid_pkg::ST_OK |-> message_id == 32'd0 && req_id == 64'd0)
    else $error("ids present on a failed message");
  // never load over a result that is still stalled
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    emit |-> !result_valid || !result_stall)
    else $error("result register overwritten");
`endif

endmodule
